@@ hw/rtl/qbve_pkg.sv @@
// Package for the quad batch vertex expander: beat types, control structs
// and shared constants. No dependencies.
`default_nettype none

package qbve_pkg;

  localparam int QPB_W                 = 14;
  localparam logic [QPB_W-1:0] QPB_RESET = 14'd5000;
  localparam int TEXTURE_SLOTS_DEFAULT = 32;
  localparam int SLOT_W                = 5;
  localparam int TEX_W                 = 16;

  // Corner order (-,-), (+,-), (+,+), (-,+); the last code closes a quad.
  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef struct packed {
    logic signed [31:0] xrow_col_x;
    logic signed [31:0] xrow_col_y;
    logic signed [31:0] xrow_shift;
    logic signed [31:0] yrow_col_x;
    logic signed [31:0] yrow_col_y;
    logic signed [31:0] yrow_shift;
    logic signed [31:0] zrow_col_x;
    logic signed [31:0] zrow_col_y;
    logic signed [31:0] zrow_shift;
    logic [63:0]        rgba;
    logic [TEX_W-1:0]   texture_id;
    logic [31:0]        tile_amount;
  } quad_beat_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [63:0]        vert_rgba;
    logic               tex_u;
    logic               tex_v;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        vert_tile;
    logic               batch_start;
    logic               last;
  } vert_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       wr_en;
    logic       resolve;
    logic       starts;
    logic       out_load;
    logic [1:0] corner;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tex_zero;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/qbve_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qbve_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qbve_datapath.sv @@
// Datapath: quad holding register, texture slot table, corner arithmetic
// and the output register. Depends on qbve_pkg and qbve_ram.
`default_nettype none

module qbve_datapath
  import qbve_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire quad_beat_t                       quad_in,
  input  wire ctrl_cmd_t                        cmd,
  input  wire logic [$clog2(TEXTURE_SLOTS)-1:0] slot_addr,
  output dp_status_t                            status,
  output vert_beat_t                            vert_out,
  output logic                                  vert_valid,
  input  wire logic                             vert_ready
);

  localparam int IDX_W = $clog2(TEXTURE_SLOTS);

  quad_beat_t         quad_r;
  logic [IDX_W-1:0]   slot_r;
  logic               starts_r;
  logic [TEX_W-1:0]   ram_rdata;
  vert_beat_t         vert_next;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic               px;
  logic               py;

  // Translation plus or minus half of each column, saturated to 32 bits.
  function automatic logic signed [31:0] corner_pos(
    input logic signed [31:0] cx,
    input logic signed [31:0] cy,
    input logic signed [31:0] sh,
    input logic               sx,
    input logic               sy
  );
    logic signed [33:0] hx;
    logic signed [33:0] hy;
    logic signed [33:0] r;
    hx = 34'(cx) >>> 1;
    hy = 34'(cy) >>> 1;
    r  = 34'(sh) + (sx ? hx : -hx) + (sy ? hy : -hy);
    if (r[33] != r[31] || r[32] != r[31]) begin
      return r[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quad_r <= quad_in;
    end
    if (cmd.resolve) begin
      slot_r   <= slot_addr;
      starts_r <= cmd.starts;
    end
  end

  qbve_ram #(
    .WIDTH (TEX_W),
    .DEPTH (TEXTURE_SLOTS)
  ) u_slot_table (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (slot_addr),
    .wdata (quad_r.texture_id),
    .re    (cmd.rd_en),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );

  assign px       = cmd.corner[0] ^ cmd.corner[1];
  assign py       = cmd.corner[1];
  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};

  always_comb begin
    vert_next.vert_x = corner_pos(quad_r.xrow_col_x, quad_r.xrow_col_y,
                                  quad_r.xrow_shift, px, py);
    vert_next.vert_y = corner_pos(quad_r.yrow_col_x, quad_r.yrow_col_y,
                                  quad_r.yrow_shift, px, py);
    vert_next.vert_z = corner_pos(quad_r.zrow_col_x, quad_r.zrow_col_y,
                                  quad_r.zrow_shift, px, py);
    vert_next.vert_rgba   = quad_r.rgba;
    vert_next.tex_u       = px;
    vert_next.tex_v       = py;
    vert_next.slot        = slot_ext[SLOT_W-1:0];
    vert_next.vert_tile   = quad_r.tile_amount;
    vert_next.batch_start = starts_r && (cmd.corner == CORNER_FIRST);
    vert_next.last        = (cmd.corner == CORNER_LAST);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vert_out <= vert_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
    end else if (cmd.out_load) begin
      vert_valid <= 1'b1;
    end else if (vert_ready) begin
      vert_valid <= 1'b0;
    end
  end

  assign status.tex_zero = (quad_r.texture_id == '0);
  assign status.hit      = (ram_rdata == quad_r.texture_id);
  assign status.out_free = !vert_valid || vert_ready;

endmodule

`default_nettype wire

@@ hw/rtl/qbve_ctrl.sv @@
// Controller: sequencing state machine, batch and slot counters, and the
// quads-per-batch register. Depends on qbve_pkg.
`default_nettype none

module qbve_ctrl
  import qbve_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             quad_valid,
  output logic                                  quad_ready,
  input  wire logic                             cfg_we,
  input  wire logic [QPB_W-1:0]                 cfg_data,
  input  wire dp_status_t                       status,
  output ctrl_cmd_t                             cmd,
  output logic [$clog2(TEXTURE_SLOTS)-1:0]      slot_addr
);

  localparam int IDX_W = $clog2(TEXTURE_SLOTS);
  localparam int CNT_W = $clog2(TEXTURE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(TEXTURE_SLOTS);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_PROBE   = 2'd1;
  localparam logic [1:0] S_COMPARE = 2'd2;
  localparam logic [1:0] S_EMIT    = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [QPB_W-1:0] qpb;
  logic [QPB_W-1:0] qib;
  logic [QPB_W-1:0] qib_next;
  logic [CNT_W-1:0] su;
  logic [CNT_W-1:0] su_next;
  logic [CNT_W-1:0] sidx;
  logic [CNT_W-1:0] sidx_next;
  logic [1:0]       corner;
  logic [1:0]       corner_next;
  logic             table_full;

  assign table_full = (su == SLOTS_FULL);
  assign quad_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    qib_next    = qib;
    su_next     = su;
    sidx_next   = sidx;
    corner_next = corner;
    cmd         = '0;
    cmd.corner  = corner;
    slot_addr   = sidx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (quad_valid) begin
          cmd.load   = 1'b1;
          sidx_next  = CNT_W'(1);
          state_next = S_PROBE;
          if (qib >= qpb) begin
            qib_next = '0;
            su_next  = CNT_W'(1);
          end
        end
      end
      S_PROBE: begin
        if (status.tex_zero) begin
          slot_addr   = '0;
          cmd.resolve = 1'b1;
          cmd.starts  = (qib == '0);
          qib_next    = qib + 1'b1;
          state_next  = S_EMIT;
        end else if (sidx < su) begin
          cmd.rd_en  = 1'b1;
          state_next = S_COMPARE;
        end else begin
          // Miss: append, opening a new batch first if the table is full.
          cmd.wr_en   = 1'b1;
          cmd.resolve = 1'b1;
          if (table_full) begin
            slot_addr  = IDX_W'(1);
            su_next    = CNT_W'(2);
            cmd.starts = 1'b1;
            qib_next   = QPB_W'(1);
          end else begin
            slot_addr  = su[IDX_W-1:0];
            su_next    = su + 1'b1;
            cmd.starts = (qib == '0);
            qib_next   = qib + 1'b1;
          end
          state_next = S_EMIT;
        end
      end
      S_COMPARE: begin
        if (status.hit) begin
          cmd.resolve = 1'b1;
          cmd.starts  = (qib == '0);
          qib_next    = qib + 1'b1;
          state_next  = S_EMIT;
        end else begin
          sidx_next  = sidx + 1'b1;
          state_next = S_PROBE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          corner_next  = corner + 1'b1;
          if (corner == CORNER_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      qpb    <= QPB_RESET;
      qib    <= '0;
      su     <= CNT_W'(1);
      sidx   <= CNT_W'(1);
      corner <= CORNER_FIRST;
    end else begin
      state  <= state_next;
      qib    <= qib_next;
      su     <= su_next;
      sidx   <= sidx_next;
      corner <= corner_next;
      if (cfg_we) begin
        qpb <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/quad_batch_vertex_expander_unit.sv @@
// Top level of the quad batch vertex expander: joins controller and datapath.
// Depends on qbve_pkg, qbve_ctrl, qbve_datapath (and qbve_ram below it).
`default_nettype none

// Each accepted quad beat yields four vertex beats, corners in the order
// (-,-), (+,-), (+,+), (-,+) with uv 00, 10, 11, 01. Every vertex position is
// the row translation plus or minus half of each column (arithmetic shift),
// saturated to signed 32 bits. A nonzero texture handle is looked up in a
// slot table held in a small RAM; a miss appends it, and slot 0 stands for
// no texture. A new batch opens when quads_per_batch quads have been taken,
// or when a miss finds the table full; batch_start marks the first vertex of
// the first quad of a batch. Quads are handled one at a time. A quad goes
// through an accept step, a RAM read and a compare for each table entry
// searched (a hit resolves in its compare step), one more step to resolve a
// miss or a zero handle, then a load for each of the four vertex beats; a
// load waits while the receiver holds off. The output register lets the next
// quad be taken while the last vertex still waits.
// The quads_per_batch register (reset 5000) is written through cfg_we and
// cfg_data only while the block is idle; the user must keep to this, as the
// block does not enforce it. The slot table needs no clearing after reset:
// only entries written in the current batch are ever read.
module quad_batch_vertex_expander_unit
  import qbve_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             quad_valid,
  output logic                  quad_ready,
  input  wire quad_beat_t       quad,
  output logic                  vert_valid,
  input  wire logic             vert_ready,
  output vert_beat_t            vert,
  input  wire logic             cfg_we,
  input  wire logic [QPB_W-1:0] cfg_data
);

  ctrl_cmd_t                        cmd;
  dp_status_t                       status;
  logic [$clog2(TEXTURE_SLOTS)-1:0] slot_addr;

  qbve_ctrl #(
    .TEXTURE_SLOTS (TEXTURE_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (quad_valid),
    .quad_ready (quad_ready),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .status     (status),
    .cmd        (cmd),
    .slot_addr  (slot_addr)
  );

  qbve_datapath #(
    .TEXTURE_SLOTS (TEXTURE_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .quad_in    (quad),
    .cmd        (cmd),
    .slot_addr  (slot_addr),
    .status     (status),
    .vert_out   (vert),
    .vert_valid (vert_valid),
    .vert_ready (vert_ready)
  );

endmodule

`default_nettype wire

@@ bench/quad_batch_vertex_expander_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quad_batch_vertex_expander_unit: offers quad beats, predicts
// the four vertex beats of each quad and checks them in order. Needs qbve_pkg and the RTL.
module quad_batch_vertex_expander_unit_test;
  import qbve_pkg::*;

  localparam int SLOTS = TEXTURE_SLOTS_DEFAULT;
  // The longest quad searches the whole slot table: a read and a compare per entry
  // plus the resolve and load steps. After the last vertex we let at least that much time pass.
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int LONG_HOLD = 300;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [QPB_W-1:0] LIMIT_TOP = {QPB_W{1'b1}};

  typedef enum {TEX_NONE, TEX_POOL, TEX_FRESH, TEX_ANY, TEX_MIX} tex_style_t;

  logic clk;
  logic rst = 1'b1;
  logic quad_valid = 1'b0;
  logic quad_ready;
  quad_beat_t quad = '0;
  logic vert_valid;
  logic vert_ready = 1'b0;
  vert_beat_t vert;
  logic cfg_we = 1'b0;
  logic [QPB_W-1:0] cfg_data = '0;

  quad_batch_vertex_expander_unit #(
    .TEXTURE_SLOTS(SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .quad_valid(quad_valid),
    .quad_ready(quad_ready),
    .quad      (quad),
    .vert_valid(vert_valid),
    .vert_ready(vert_ready),
    .vert      (vert),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the slot table, the batch counters and the
  // quads_per_batch register. Only entries below slots_taken are ever read.
  // ---------------------------------------------------------------------------
  logic [TEX_W-1:0] slot_handle [SLOTS];
  int slots_taken = 1;
  int batch_quads = 0;
  logic [QPB_W-1:0] batch_limit = QPB_RESET;
  vert_beat_t expected_verts[$];

  int mismatches = 0;
  int quads_queued = 0;
  int quads_accepted = 0;

  // The run ends here if the block hangs or drops vertex beats.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d vertex beats still expected", $time,
             expected_verts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One vertex coordinate: translation plus or minus half of each column. The
  // halves are arithmetic shifts, so odd negative columns round toward minus
  // infinity, and the sum is clamped to the signed 32-bit range.
  function automatic logic [31:0] corner_sum(input logic [31:0] col_x, col_y, shift,
                                             input bit plus_x, plus_y);
    longint half_x, half_y, acc;
    half_x = longint'($signed(col_x)) >>> 1;
    half_y = longint'($signed(col_y)) >>> 1;
    acc = longint'($signed(shift));
    acc += plus_x ? half_x : -half_x;
    acc += plus_y ? half_y : -half_y;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic void open_batch();
    batch_quads = 0;
    slots_taken = 1;
  endfunction

  // Works out the four vertex beats of an accepted quad and queues them.
  function automatic void expand_quad(input quad_beat_t q);
    int slot_no;
    bit opens, px, py;
    vert_beat_t v;
    if (batch_quads >= int'(batch_limit)) open_batch();
    slot_no = 0;
    if (q.texture_id != '0) begin
      for (int i = 1; i < slots_taken; i++) begin
        if (slot_no == 0 && slot_handle[i] == q.texture_id) slot_no = i;
      end
      // A miss appends the handle; with the table full it opens a batch first.
      if (slot_no == 0) begin
        if (slots_taken >= SLOTS) open_batch();
        slot_no = slots_taken;
        slot_handle[slot_no] = q.texture_id;
        slots_taken++;
      end
    end
    opens = (batch_quads == 0);
    for (int k = 0; k < 4; k++) begin
      px = (k == 1) || (k == 2);
      py = (k >= 2);
      v.vert_x      = corner_sum(q.xrow_col_x, q.xrow_col_y, q.xrow_shift, px, py);
      v.vert_y      = corner_sum(q.yrow_col_x, q.yrow_col_y, q.yrow_shift, px, py);
      v.vert_z      = corner_sum(q.zrow_col_x, q.zrow_col_y, q.zrow_shift, px, py);
      v.vert_rgba   = q.rgba;
      v.tex_u       = px;
      v.tex_v       = py;
      v.slot        = slot_no[SLOT_W-1:0];
      v.vert_tile   = q.tile_amount;
      v.batch_start = (k == CORNER_FIRST) && opens;
      v.last        = (k == CORNER_LAST);
      expected_verts.push_back(v);
    end
    batch_quads = (batch_quads + 1) & ((1 << QPB_W) - 1);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's own
  // updates at that edge land.
  // ---------------------------------------------------------------------------
  logic quad_taken = 1'b0;
  logic vert_taken = 1'b0;
  vert_beat_t want;

  always @(posedge clk) begin
    quad_taken <= !rst && quad_valid && quad_ready;
    vert_taken <= !rst && vert_valid && vert_ready;
    if (!rst && quad_valid && quad_ready) begin
      expand_quad(quad);
      quads_accepted++;
    end
    if (!rst && vert_valid && vert_ready) begin
      if (expected_verts.size() == 0) begin
        $display("%0t: vertex beat with nothing expected, got %p", $time, vert);
        mismatches++;
      end else begin
        want = expected_verts.pop_front();
        check_field("vert_x", $unsigned(want.vert_x), $unsigned(vert.vert_x));
        check_field("vert_y", $unsigned(want.vert_y), $unsigned(vert.vert_y));
        check_field("vert_z", $unsigned(want.vert_z), $unsigned(vert.vert_z));
        check_field("vert_rgba", want.vert_rgba, vert.vert_rgba);
        check_field("tex_u", want.tex_u, vert.tex_u);
        check_field("tex_v", want.tex_v, vert.tex_v);
        check_field("slot", want.slot, vert.slot);
        check_field("vert_tile", want.vert_tile, vert.vert_tile);
        check_field("batch_start", want.batch_start, vert.batch_start);
        check_field("last", want.last, vert.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers quads from pending_quads at the falling edge. A beat stays up,
  // unchanged, until the monitor has seen it taken; then a random gap passes
  // before the next one, except in quiet phases, which send without a gap.
  // ---------------------------------------------------------------------------
  quad_beat_t pending_quads[$];
  bit calm = 1'b0;
  int send_gap = 0;
  logic offer_next;

  always @(negedge clk) begin
    offer_next = quad_valid && !quad_taken;
    if (rst) begin
      offer_next = 1'b0;
    end else if (!offer_next) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_quads.size() > 0) begin
        quad <= pending_quads.pop_front();
        offer_next = 1'b1;
        send_gap = calm ? 0 : $urandom_range(0, 9);
      end
    end
    quad_valid <= offer_next;
  end

  // ---------------------------------------------------------------------------
  // Receiver: after every vertex beat it stalls for a random gap, except in quiet
  // phases. When the main sequence asks for it, it also holds ready low for a stretch
  // that LONG_HOLD sets, counted here, so that the block backs up and drops quad_ready.
  // ---------------------------------------------------------------------------
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int recv_gap = 0;
  logic take_next;

  always @(negedge clk) begin
    if (rst) begin
      take_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      take_next = 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      take_next = 1'b0;
    end else begin
      if (vert_taken) recv_gap = calm ? 0 : $urandom_range(0, 9);
      if (recv_gap > 0) begin
        recv_gap--;
        take_next = 1'b0;
      end else begin
        take_next = 1'b1;
      end
    end
    vert_ready <= take_next;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  logic [TEX_W-1:0] next_fresh = 16'h0100;

  task automatic queue_quad(input quad_beat_t q);
    pending_quads.push_back(q);
    quads_queued++;
  endtask

  // Waits until every queued quad is taken and every vertex beat has arrived,
  // then lets the block settle before the register is touched.
  task automatic wait_idle();
    while (quads_accepted != quads_queued || expected_verts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written while the block is idle, so the predictor can
  // take the new value at once.
  task automatic write_batch_limit(input logic [QPB_W-1:0] limit);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    batch_limit = limit;
  endtask

  // Q16.16 values weighted toward the corners of the range and small numbers.
  function automatic logic [31:0] random_q16();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 3);
      4, 5: begin
        mag = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: return $urandom;
    endcase
  endfunction

  // Texture handles: none, a small pool that hits often, never-seen handles that
  // fill the slot table, or anything at all.
  function automatic logic [TEX_W-1:0] pick_texture(input tex_style_t style);
    tex_style_t s;
    s = style;
    if (s == TEX_MIX) begin
      case ($urandom_range(0, 19))
        0, 1, 2: s = TEX_NONE;
        3, 4, 5: s = TEX_ANY;
        6, 7, 8, 9, 10, 11: s = TEX_FRESH;
        default: s = TEX_POOL;
      endcase
    end
    case (s)
      TEX_NONE: return '0;
      TEX_POOL: return $urandom_range(0, 6);
      TEX_FRESH: begin
        next_fresh++;
        if (next_fresh == '0) next_fresh++;
        return next_fresh;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic quad_beat_t random_quad(input logic [TEX_W-1:0] tex);
    quad_beat_t q;
    q.xrow_col_x  = random_q16();
    q.xrow_col_y  = random_q16();
    q.xrow_shift  = random_q16();
    q.yrow_col_x  = random_q16();
    q.yrow_col_y  = random_q16();
    q.yrow_shift  = random_q16();
    q.zrow_col_x  = random_q16();
    q.zrow_col_y  = random_q16();
    q.zrow_shift  = random_q16();
    q.rgba        = {$urandom, $urandom};
    q.texture_id  = tex;
    q.tile_amount = $urandom_range(0, 1) ? $urandom : random_q16();
    return q;
  endfunction

  // Directed quads rotate three values through the rows so that each row sees
  // them in a different role.
  function automatic quad_beat_t directed_quad(input logic [31:0] a, b, c,
                                               input logic [63:0] rgba,
                                               input logic [TEX_W-1:0] tex,
                                               input logic [31:0] tile);
    quad_beat_t q;
    q.xrow_col_x  = a;
    q.xrow_col_y  = b;
    q.xrow_shift  = c;
    q.yrow_col_x  = b;
    q.yrow_col_y  = c;
    q.yrow_shift  = a;
    q.zrow_col_x  = c;
    q.zrow_col_y  = a;
    q.zrow_shift  = b;
    q.rgba        = rgba;
    q.texture_id  = tex;
    q.tile_amount = tile;
    return q;
  endfunction

  task automatic run_phase(input int count, input logic [QPB_W-1:0] limit,
                           input tex_style_t style);
    write_batch_limit(limit);
    for (int i = 0; i < count; i++) queue_quad(random_quad(pick_texture(style)));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats under the reset limit. The first quad opens a batch. The
    // all-max and all-min quads saturate high and low on the same corner, odd
    // negative columns check that halving rounds down, and the repeated handles hit
    // the slots that earlier quads took. The bit patterns toggle every field bit.
    queue_quad(directed_quad('0, '0, '0, '0, '0, '0));
    queue_quad(directed_quad(Q_MAX, Q_MAX, Q_MAX, '1, 16'hffff, '1));
    queue_quad(directed_quad(Q_MIN, Q_MIN, Q_MIN, '0, 16'hffff, '0));
    queue_quad(directed_quad(32'hffff_ffff, 32'hffff_fffd, '0,
                             64'h0123_4567_89ab_cdef, 16'h0001, 32'h0001_0000));
    queue_quad(directed_quad(32'd1, 32'd3, 32'd5, 64'hfedc_ba98_7654_3210, 16'h0002,
                             32'h0000_8000));
    queue_quad(directed_quad(Q_MIN, Q_MAX, '0, 64'hffff_0000_ffff_0000, 16'h0001,
                             32'hffff_0000));
    queue_quad(directed_quad(Q_MAX, Q_MIN, 32'hffff_ffff, 64'h0000_ffff_0000_ffff, '0,
                             32'h0000_ffff));
    queue_quad(directed_quad(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                             64'h5555_5555_5555_5555, 16'h5555, 32'h5555_5555));
    queue_quad(directed_quad(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                             64'haaaa_aaaa_aaaa_aaaa, 16'haaaa, 32'haaaa_aaaa));
    queue_quad(directed_quad(32'h0001_0000, 32'hffff_0000, 32'h0010_8000,
                             64'h8000_0000_0000_0001, 16'h0002, 32'h8000_0001));
    queue_quad(directed_quad(Q_MAX, 32'h0000_0001, Q_MIN, '1, 16'h5555, 32'd0));
    queue_quad(directed_quad(Q_MIN, 32'hffff_ffff, Q_MAX, '0, 16'haaaa, '1));
    wait_idle();

    // A limit of zero opens a batch on every quad, a limit of one does the same
    // through the ordinary count, and three gives short batches.
    run_phase(20, '0, TEX_POOL);
    run_phase(20, 14'd1, TEX_MIX);
    run_phase(60, 14'd3, TEX_POOL);

    // Long batches fed with handles never seen before: the table fills after
    // SLOTS-1 textures and the next miss opens a batch on its own.
    run_phase(80, 14'd8192, TEX_FRESH);

    // The receiver holds off for a long stretch while quads keep coming, so the
    // block backs up and stalls its input.
    write_batch_limit(14'd5);
    holds_asked++;
    for (int i = 0; i < 40; i++) queue_quad(random_quad(pick_texture(TEX_MIX)));
    wait_idle();

    // A stretch with no idling on either side, at the top of the register range.
    calm = 1'b1;
    run_phase(60, LIMIT_TOP, TEX_MIX);
    calm = 1'b0;

    run_phase(60, 14'($urandom_range(2, 40)), TEX_ANY);
    run_phase(80, QPB_RESET, TEX_MIX);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
